// ===== src/pkam_pkg.sv =====
// Package for the path keepalive monitor: item, table entry and decision types,
// action, status and event codes. No dependencies.
package pkam_pkg;

  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned PATH_W     = 4;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned HOLDOFF_W  = 8;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 8'd10;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_CHECK   = 2'd1,
    ACT_RECEIVE = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DOWN = 2'd1;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_SEND = 2'd1,
    EV_DOWN = 2'd2,
    EV_UP   = 2'd3
  } event_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    action_t                 action;
    logic [PATH_W-1:0]       path;
    logic [1:0]              status;
    logic [INTERVAL_W-1:0]   interval;
    logic [INTERVAL_W-1:0]   dead;
  } item_t;

  typedef struct packed {
    logic [STAMP_W-1:0] received;
    logic [STAMP_W-1:0] sent;
    logic [STAMP_W-1:0] commanded;
  } entry_t;

  typedef struct packed {
    event_t  kind;
    logic    wr_en;
    logic    tick;
    entry_t  entry;
  } decision_t;

endpackage

// ===== src/path_keepalive_monitor_top.sv =====
// Top level of the path keepalive monitor: handshake, per-path timestamp memory,
// seconds counter and result register. Uses pkam_pkg and pkam_eval.
//
// Usage:
//   s_*   : item channel. s_tuser carries the action (tick, check, receive);
//           s_tdata carries path, status, keepalive interval and dead time.
//   m_*   : result channel, one result transaction per item. m_tuser is the
//           event kind, m_tdata the path (zero when the kind is "nothing").
//   cfg_* : write of the hold-off register (seconds), always ready.
//   Timing: an item is taken in the idle cycle; the path's entry is read from
//   the memory at that edge into a register, evaluated and written back in the
//   evaluate state, when the result also enters the output register. The block
//   takes no new item while one is in the evaluate state: the idle/evaluate
//   handshake around the memory read-modify-write alternates the two states.
//   Stall: while a result waits in the output register the next item is still
//   taken and read; its evaluation waits until the output register frees up.
//   Reset: clears the seconds counter, the per-entry valid bits (an entry never
//   written reads as all-zero timestamps), the result register and sets the
//   hold-off back to 10 s. No clearing pass is needed.
module path_keepalive_monitor_top #(
  parameter int unsigned PATHS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // path_id[3:0], path_status[5:4],
                                 // keepalive_interval[21:6], dead_time[37:22], zero pad
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // event_path[3:0], zero pad
  output logic [1:0]  m_tuser,   // event_kind[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // holdoff_seconds[7:0]
);

  localparam int unsigned AW = (PATHS > 1) ? $clog2(PATHS) : 1;

  pkam_pkg::state_t    state;
  pkam_pkg::state_t    state_next;
  pkam_pkg::item_t     item;
  pkam_pkg::item_t     in_item;
  pkam_pkg::entry_t    mem [PATHS];
  logic [PATHS-1:0]    valid;
  pkam_pkg::entry_t    rd_data;
  logic                rd_valid;
  pkam_pkg::entry_t    cur_entry;
  pkam_pkg::decision_t dec;
  logic [pkam_pkg::STAMP_W-1:0]   now_seconds;
  logic [pkam_pkg::HOLDOFF_W-1:0] holdoff;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                in_range;
  logic                s_accept;
  logic                eval_fire;

  assign in_item.action   = pkam_pkg::action_t'(s_tuser);
  assign in_item.path     = s_tdata[3:0];
  assign in_item.status   = s_tdata[5:4];
  assign in_item.interval = s_tdata[21:6];
  assign in_item.dead     = s_tdata[37:22];

  assign s_accept = s_tvalid && s_tready;
  assign rd_addr  = AW'(in_item.path);
  assign wr_addr  = AW'(item.path);
  assign in_range = 9'(item.path) < 9'(PATHS);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pkam_pkg::ST_IDLE: if (s_tvalid) state_next = pkam_pkg::ST_EVAL;
      pkam_pkg::ST_EVAL: if (!m_tvalid || m_tready) state_next = pkam_pkg::ST_IDLE;
      default:           state_next = pkam_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready  = 1'b0;
    eval_fire = 1'b0;
    unique case (state)
      pkam_pkg::ST_IDLE: s_tready  = 1'b1;
      pkam_pkg::ST_EVAL: eval_fire = !m_tvalid || m_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pkam_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture and registered memory read
  always_ff @(posedge clk) begin
    if (s_accept) begin
      item     <= in_item;
      rd_data  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // unwritten entries read as the start time
  assign cur_entry = rd_valid ? rd_data : '0;

  pkam_eval u_eval (
    .item     (item),
    .in_range (in_range),
    .entry    (cur_entry),
    .now      (now_seconds),
    .holdoff  (holdoff),
    .dec      (dec)
  );

  // write back; the next read comes only from the idle state, after the write, so no forwarding
  always_ff @(posedge clk) begin
    if (eval_fire && dec.wr_en) begin
      mem[wr_addr] <= dec.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      now_seconds <= '0;
    end else if (eval_fire) begin
      if (dec.wr_en) valid[wr_addr] <= 1'b1;
      if (dec.tick)  now_seconds <= now_seconds + 1'b1;
    end
  end

  // hold-off register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff <= pkam_pkg::HOLDOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      holdoff <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eval_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      m_tuser <= dec.kind;
      m_tdata <= (dec.kind == pkam_pkg::EV_NONE) ? 8'd0 : {4'd0, item.path};
    end
  end

endmodule

// ===== src/pkam_eval.sv =====
// Per-item decision logic of the path keepalive monitor: takes the stored entry
// of one path and the item, gives the event and the entry to write back. Uses pkam_pkg.
module pkam_eval (
  input  pkam_pkg::item_t                       item,
  input  logic                                  in_range,
  input  pkam_pkg::entry_t                      entry,
  input  logic [pkam_pkg::STAMP_W-1:0]          now,
  input  logic [pkam_pkg::HOLDOFF_W-1:0]        holdoff,
  output pkam_pkg::decision_t                   dec
);

  logic [pkam_pkg::STAMP_W-1:0] since_rcv;
  logic [pkam_pkg::STAMP_W-1:0] since_sent;
  logic [pkam_pkg::STAMP_W-1:0] since_cmd;
  logic in_holdoff;
  logic is_dead;
  logic send_due;
  logic enabled;
  logic st_ok;
  logic st_down;

  assign since_rcv  = now - entry.received;
  assign since_sent = now - entry.sent;
  assign since_cmd  = now - entry.commanded;
  assign in_holdoff = since_cmd < pkam_pkg::STAMP_W'(holdoff);
  assign is_dead    = since_rcv > pkam_pkg::STAMP_W'(item.dead);
  assign send_due   = since_sent >= pkam_pkg::STAMP_W'(item.interval);
  assign enabled    = item.interval != '0;
  assign st_ok      = item.status == pkam_pkg::STATUS_OK;
  assign st_down    = item.status == pkam_pkg::STATUS_DOWN;

  always_comb begin
    dec.kind  = pkam_pkg::EV_NONE;
    dec.wr_en = 1'b0;
    dec.tick  = 1'b0;
    dec.entry = entry;
    unique case (item.action)
      pkam_pkg::ACT_TICK: begin
        dec.tick = 1'b1;
      end
      pkam_pkg::ACT_CHECK: begin
        if (in_range && enabled) begin
          dec.wr_en = 1'b1;
          priority if (st_ok && is_dead) begin
            if (!in_holdoff) begin
              dec.kind            = pkam_pkg::EV_DOWN;
              dec.entry.commanded = now;
            end
          end else if (st_ok && send_due) begin
            dec.kind       = pkam_pkg::EV_SEND;
            dec.entry.sent = now;
          end else begin
            // nothing due: entry written back unchanged
          end
        end
      end
      pkam_pkg::ACT_RECEIVE: begin
        if (in_range && enabled) begin
          dec.wr_en = 1'b1;
          priority if (st_down && in_holdoff) begin
            // blocked by the hold-off: receive time stays as it was
          end else if (st_down) begin
            dec.kind            = pkam_pkg::EV_UP;
            dec.entry.commanded = now;
            dec.entry.received  = now;
          end else begin
            dec.entry.received  = now;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/pkam_checker.sv =====
// Port-level checks for the path keepalive monitor, bound to the top level.
// Uses pkam_pkg for event codes.
module pkam_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an empty event carries no path
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == pkam_pkg::EV_NONE) |-> m_tdata == 8'd0)
    else $error("empty event with nonzero path");

  // one item in flight: not ready right after an accepted transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken during evaluation");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind path_keepalive_monitor_top pkam_checker u_pkam_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
